>>> design/mps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mps_pkg;

  // Packet kinds carried on the input tuser
  localparam logic CMD_MOTION = 1'b0;
  localparam logic CMD_CLAW   = 1'b1;

  // Fixed packet bytes
  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] ID_MOTION  = 8'h01;
  localparam logic [7:0] CLAW_CLOSE = 8'h03;
  localparam logic [7:0] CLAW_OPEN  = 8'h02;

  // Magnitude saturation: floor(sqrt(s)) >= MAG_LIMIT exactly when s >= MAG_LIMIT^2
  localparam int         MAG_W       = 7;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 7'd99;
  localparam logic [15:0] MAG_LIMIT_SQ = 16'd9801;
  localparam logic [2:0] ROOT_TOP_BIT = 3'(MAG_W - 1);

  // Byte positions within a packet
  localparam int         PKT_IDX_W = 3;
  localparam logic [PKT_IDX_W-1:0] BYTE_START = 3'd0;
  localparam logic [PKT_IDX_W-1:0] BYTE_ID    = 3'd1;
  localparam logic [PKT_IDX_W-1:0] BYTE_VX    = 3'd2;
  localparam logic [PKT_IDX_W-1:0] BYTE_VY    = 3'd3;
  localparam logic [PKT_IDX_W-1:0] BYTE_MAG   = 3'd4;
  localparam logic [PKT_IDX_W-1:0] BYTE_ZLO   = 3'd5;
  localparam logic [PKT_IDX_W-1:0] BYTE_ZHI   = 3'd6;
  localparam logic [PKT_IDX_W-1:0] BYTE_LAST  = 3'd7;

  // Queue between front and back (depth must stay a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic             cmd;
    logic             btn;
    logic [7:0]       vel_x;
    logic [7:0]       vel_y;
    logic [15:0]      height;
    logic [MAG_W-1:0] mag;
  } mps_entry_t;

  function automatic logic [7:0] pkt_byte(mps_entry_t e, logic [PKT_IDX_W-1:0] idx);
    logic [7:0] b;
    logic       motion;
    motion = (e.cmd == CMD_MOTION);
    b      = 8'h00;
    case (idx)
      BYTE_START: b = START_BYTE;
      BYTE_ID:    b = motion ? ID_MOTION : (e.btn ? CLAW_CLOSE : CLAW_OPEN);
      BYTE_VX:    b = motion ? e.vel_x : 8'h00;
      BYTE_VY:    b = motion ? e.vel_y : 8'h00;
      BYTE_MAG:   b = motion ? {1'b0, e.mag} : 8'h00;
      BYTE_ZLO:   b = motion ? e.height[7:0] : 8'h00;
      BYTE_ZHI:   b = motion ? e.height[15:8] : 8'h00;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> design/motion_packet_serializer.sv
// Channel  Dir  Handshake                      Payload (low bit up)
// s_axis   in   s_axis_tvalid/s_axis_tready    tdata: vel_x[7:0] vel_y[15:8]
//                                               height[31:16] button_pressed[32];
//                                               tuser: command
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata: out_byte; tlast: last
//
// Each item yields eight words. A motion item holds the front to capture it and form
// vx^2+vy^2, then to resolve the root bit by bit on one 7x7 multiplier; a claw item
// skips the root. The back emits a word a cycle while a packet is queued and m_axis
// is ready; the front accepts a new item as it pushes. A two-entry queue parts the two sides
// and the output word is registered: input continues while m_axis stalls until the
// queue fills. Reset clears control state only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module motion_packet_serializer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // vel_x, vel_y, height, button_pressed
  input  wire logic        s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_byte
  output logic             m_axis_tlast
);
  import mps_pkg::*;

  mps_entry_t push_entry;
  mps_entry_t head_entry;
  logic       push, full, q_valid, pop;
  logic [6:0] unused_pad;

  // Padding bits of the input word carry nothing
  assign unused_pad = s_axis_tdata[39:33];

  // Front: capture, classify and work out the magnitude
  mps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid && (unused_pad == unused_pad)),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .vel_x_i    (s_axis_tdata[7:0]),
    .vel_y_i    (s_axis_tdata[15:8]),
    .height_i   (s_axis_tdata[31:16]),
    .btn_i      (s_axis_tdata[32]),
    .push_o     (push),
    .full_i     (full),
    .entry_o    (push_entry)
  );

  // Hold finished packet descriptors until the back is free
  mps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .head_o      (head_entry)
  );

  // Back: advance through the eight words of the head packet
  mps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> design/mps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mps_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [7:0]        vel_x_i,
  input  wire logic [7:0]        vel_y_i,
  input  wire logic [15:0]       height_i,
  input  wire logic              btn_i,
  output logic                   push_o,
  input  wire logic              full_i,
  output mps_pkg::mps_entry_t    entry_o
);
  import mps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]       st_q, st_d;
  logic [2:0]       bit_q, bit_d;
  logic [MAG_W-1:0] root_q, root_d;
  logic [15:0]      sum_q;
  logic             sat_q;
  logic             cmd_q, btn_q;
  logic [7:0]       vx_q, vy_q;
  logic [15:0]      z_q;

  logic             accept;
  logic [7:0]       abs_x, abs_y;
  logic [15:0]      sum_in;
  logic [MAG_W-1:0] trial;
  logic [2*MAG_W-1:0] trial_sq;

  // Absolute values of the velocities; -128 gives 128, which fits unsigned
  assign abs_x  = vel_x_i[7] ? (8'd0 - vel_x_i) : vel_x_i;
  assign abs_y  = vel_y_i[7] ? (8'd0 - vel_y_i) : vel_y_i;
  assign sum_in = (abs_x * abs_x) + (abs_y * abs_y);

  assign push_o     = (st_q == ST_PUSH) && !full_i;
  assign in_ready_o = (st_q == ST_IDLE) || push_o;
  assign accept     = in_valid_i && in_ready_o;

  // One result bit a cycle, from the top bit down
  assign trial    = root_q | (MAG_W'(1) << bit_q);
  assign trial_sq = trial * trial;

  always_comb begin
    st_d   = st_q;
    bit_d  = bit_q;
    root_d = root_q;
    case (st_q)
      ST_ROOT: begin
        if ({2'b00, trial_sq} <= sum_q) begin
          root_d = trial;
        end
        if (bit_q == 3'd0) begin
          st_d = ST_PUSH;
        end else begin
          bit_d = bit_q - 3'd1;
        end
      end
      ST_PUSH: begin
        if (push_o) begin
          st_d = ST_IDLE;
        end
      end
      default: ;
    endcase
    if (accept) begin
      root_d = '0;
      bit_d  = ROOT_TOP_BIT;
      st_d   = (cmd_i == CMD_MOTION) ? ST_ROOT : ST_PUSH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      bit_q  <= '0;
      root_q <= '0;
    end else begin
      st_q   <= st_d;
      bit_q  <= bit_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      btn_q <= btn_i;
      vx_q  <= vel_x_i;
      vy_q  <= vel_y_i;
      z_q   <= height_i;
      sum_q <= sum_in;
      sat_q <= (sum_in >= MAG_LIMIT_SQ);
    end
  end

  always_comb begin
    entry_o.cmd    = cmd_q;
    entry_o.btn    = btn_q;
    entry_o.vel_x  = vx_q;
    entry_o.vel_y  = vy_q;
    entry_o.height = z_q;
    entry_o.mag    = sat_q ? MAG_LIMIT : root_q;
  end

  a_mag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (entry_o.cmd == CMD_MOTION) |-> entry_o.mag <= MAG_LIMIT)
    else $error("magnitude above limit");

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PUSH) && (cmd_q == CMD_MOTION) && !sat_q |->
      {2'b00, 14'(root_q) * 14'(root_q)} <= sum_q)
    else $error("root exceeds square root of sum");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !push_o)
    else $error("push into full queue");

endmodule

`default_nettype wire

>>> design/mps_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mps_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire mps_pkg::mps_entry_t push_data_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output mps_pkg::mps_entry_t    head_o
);
  import mps_pkg::*;

  mps_entry_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> design/mps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mps_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire mps_pkg::mps_entry_t q_head_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_last_o
);
  import mps_pkg::*;

  logic [PKT_IDX_W-1:0] idx_q;
  logic                 ov_q;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic                 load;

  // Refill the output register whenever it is empty or being drained and a packet is queued
  assign load    = q_valid_i && (!ov_q || out_ready_i);
  assign q_pop_o = load && (idx_q == BYTE_LAST);

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_q + 1'b1;
        ov_q  <= 1'b1;
      end else if (out_ready_i) begin
        ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= pkt_byte(q_head_i, idx_q);
      last_q <= (idx_q == BYTE_LAST);
    end
  end

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && last_q |-> idx_q == BYTE_START)
    else $error("last word without packet wrap");

  a_start_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && (idx_q == BYTE_START) |=> byte_q == START_BYTE)
    else $error("packet does not open with start byte");

  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> idx_q == BYTE_START)
    else $error("pop away from packet end");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mps_pkg::*;

  // One expected output word: packet byte plus end-of-packet marker
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_word_t;

  // Directed stimulus row; typed rows carry a hand-worked magnitude
  typedef struct {
    logic        cmd;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [15:0] z;
    logic        btn;
    bit          typed;
    logic [6:0]  mag;
  } stim_row_t;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 138;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // vel_x, vel_y, height, button_pressed
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;

  pkt_word_t   expected_words[$];
  int unsigned mismatch_count = 0;
  bit          calm = 1'b0;          // suppress idling on both sides
  stim_row_t   directed_rows [0:NUM_DIRECTED-1];

  motion_packet_serializer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Floor square root of vx^2 + vy^2, held at the saturation limit
  function automatic logic [6:0] velocity_magnitude(logic signed [7:0] vx,
                                                    logic signed [7:0] vy);
    int ax;
    int ay;
    int sum;
    int root;
    ax = int'(vx);
    ay = int'(vy);
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    sum  = ax * ax + ay * ay;
    root = 0;
    while (root < int'(MAG_LIMIT) && (root + 1) * (root + 1) <= sum) root++;
    return 7'(root);
  endfunction

  // Queue the eight words of one packet, byte 0 first
  task automatic queue_packet(logic cmd, logic [7:0] vx, logic [7:0] vy,
                              logic [15:0] z, logic btn, logic [6:0] mag);
    logic [7:0] bytes [0:7];
    for (int i = 0; i < 8; i++) bytes[i] = 8'h00;
    bytes[0] = START_BYTE;
    if (cmd == CMD_MOTION) begin
      bytes[1] = ID_MOTION;
      bytes[2] = vx;
      bytes[3] = vy;
      bytes[4] = {1'b0, mag};
      bytes[5] = z[7:0];
      bytes[6] = z[15:8];
    end else begin
      bytes[1] = btn ? CLAW_CLOSE : CLAW_OPEN;
    end
    for (int i = 0; i < 8; i++) expected_words.push_back('{bytes[i], i == 7});
  endtask

  // Present one word on s_axis, hold it until taken, then record its packet.
  // tvalid stays high into the next word unless a gap is drawn.
  task automatic send_word(logic cmd, logic [7:0] vx, logic [7:0] vy,
                           logic [15:0] z, logic btn, logic [6:0] mag);
    if (!calm && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 40) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, btn, z, vy, vx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queue_packet(cmd, vx, vy, z, btn, mag);
  endtask

  // Sink side: stall at random, check every word taken against the oldest
  // expectation
  always @(posedge clk_i or negedge rst_ni) begin
    pkt_word_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte 0x%02h last %0b", m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    logic        cmd;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [15:0] z;
    logic        btn;
    int          pick;

    // Extremes, exact squares, the saturation edge and both claw codes.
    // Magnitudes here are worked by hand; the last rows go to the predictor.
    directed_rows = '{
      '{CMD_MOTION, 8'h00, 8'h00, 16'h0000, 1'b0, 1'b1, 7'd0},
      '{CMD_MOTION, 8'h80, 8'h80, 16'hFFFF, 1'b1, 1'b1, 7'd99},
      '{CMD_MOTION, 8'h7F, 8'h7F, 16'h0000, 1'b0, 1'b1, 7'd99},
      '{CMD_MOTION, 8'h03, 8'h04, 16'h1234, 1'b0, 1'b1, 7'd5},
      '{CMD_MOTION, 8'hFD, 8'hFC, 16'h00FF, 1'b1, 1'b1, 7'd5},
      '{CMD_MOTION, 8'h63, 8'h00, 16'hFF00, 1'b0, 1'b1, 7'd99},
      '{CMD_MOTION, 8'h62, 8'h00, 16'h8001, 1'b0, 1'b1, 7'd98},
      '{CMD_MOTION, 8'h46, 8'h46, 16'h7FFE, 1'b0, 1'b1, 7'd98},
      '{CMD_MOTION, 8'hBA, 8'hBA, 16'h0001, 1'b1, 1'b1, 7'd98},
      '{CMD_MOTION, 8'h80, 8'h00, 16'hA55A, 1'b0, 1'b1, 7'd99},
      '{CMD_MOTION, 8'h00, 8'h7F, 16'h5AA5, 1'b0, 1'b1, 7'd99},
      '{CMD_MOTION, 8'h01, 8'h01, 16'h0100, 1'b0, 1'b1, 7'd1},
      '{CMD_MOTION, 8'hFF, 8'hFF, 16'h00FF, 1'b0, 1'b1, 7'd1},
      '{CMD_MOTION, 8'h00, 8'h0A, 16'h0000, 1'b0, 1'b1, 7'd10},
      '{CMD_CLAW,   8'h00, 8'h00, 16'h0000, 1'b0, 1'b1, 7'd0},
      '{CMD_CLAW,   8'h00, 8'h00, 16'h0000, 1'b1, 1'b1, 7'd0},
      '{CMD_CLAW,   8'hFF, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 7'd0},
      '{CMD_CLAW,   8'hAA, 8'h55, 16'h1234, 1'b0, 1'b1, 7'd0},
      '{CMD_MOTION, 8'h05, 8'h0C, 16'h4321, 1'b1, 1'b1, 7'd13},
      '{CMD_MOTION, 8'h0B, 8'h0B, 16'h0000, 1'b0, 1'b0, 7'd0},
      '{CMD_MOTION, 8'h90, 8'h31, 16'hC3C3, 1'b1, 1'b0, 7'd0},
      '{CMD_CLAW,   8'h12, 8'h34, 16'h5678, 1'b1, 1'b0, 7'd0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].vx, directed_rows[i].vy,
                directed_rows[i].z, directed_rows[i].btn,
                directed_rows[i].typed ? directed_rows[i].mag
                                       : velocity_magnitude(directed_rows[i].vx,
                                                            directed_rows[i].vy));
    end

    // Mostly motion words; claw words carry junk in the ignored fields.
    // A middle stretch runs with no idling on either side.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 60 && n < 100);
      cmd  = ($urandom_range(99) < 65) ? CMD_MOTION : CMD_CLAW;
      btn  = 1'($urandom_range(1));
      vx   = 8'($urandom_range(255));
      vy   = 8'($urandom_range(255));
      pick = $urandom_range(9);
      if (pick == 0) vx = 8'h80;
      else if (pick == 1) vx = 8'h7F;
      pick = $urandom_range(9);
      if (pick == 0) vy = 8'h80;
      else if (pick == 1) vy = 8'h7F;
      else if (pick == 2) vy = 8'($urandom_range(8)) - 8'd4;
      z = 16'($urandom_range(16'hFFFF));
      pick = $urandom_range(15);
      if (pick == 0) z = 16'h0000;
      else if (pick == 1) z = 16'hFFFF;
      send_word(cmd, vx, vy, z, btn, velocity_magnitude(vx, vy));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, then give the block a little longer to show any stray word
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
